// File: hdl/max_heap_builder_unit_defines.svh
// Assertion macros for the max heap builder block.
// Included by max_heap_builder_unit, which checks its own logic; no other dependencies.
`ifndef MAX_HEAP_BUILDER_UNIT_DEFINES_SVH
`define MAX_HEAP_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MHB_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("mhb assertion failed");
`define MHB_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error("mhb forbidden condition seen");
`else
`define MHB_ASSERT(lbl, clk_s, rst_n_s, prop)
`define MHB_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond)
`endif

`endif

// File: hdl/mhb_pkg.sv
// Shared constants and sequencer state type of the max heap builder.
// No dependencies.
package mhb_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_HNEXT,
		ST_HCAP,
		ST_CHILD,
		ST_RDR,
		ST_CMP,
		ST_ERD,
		ST_EWAIT
	} state_t;

endpackage

// File: hdl/mhb_if.sv
// Valid/ready channel interfaces for element input and heap output words.
// Depends on mhb_pkg for the data width.
interface mhb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [mhb_pkg::DATA_W-1:0] elem_value;
	logic                              last_item;

	modport source (output valid, output elem_value, output last_item, input ready);
	modport sink (input valid, input elem_value, input last_item, output ready);
endinterface

interface mhb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [mhb_pkg::DATA_W-1:0] heap_value;
	logic                              last_out;

	modport source (output valid, output heap_value, output last_out, input ready);
	modport sink (input valid, input heap_value, input last_out, output ready);
endinterface

// File: hdl/mhb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/max_heap_builder_unit.sv
// Max heap builder top level: element store, sift-down sequencer, output register.
// Depends on mhb_pkg, mhb_if, mhb_ram and max_heap_builder_unit_defines.svh.
//
// Usage:
//   elem: signed 32-bit words in array order, last_item on the final one.
//   While loading, one word is taken per cycle. Words beyond DEPTH are
//   dropped; a dropped word with last_item still closes the array.
//   After the closing word, elem.ready stays low while the array of n words
//   is rearranged into a max-heap by sift-down from n/2-1 to 0. Each sift
//   starts with a parent read (HNEXT, HCAP), moves down each level with a
//   left read, a right read and a compare-and-write (CHILD, RDR, CMP), and
//   ends on a write of the parent word, all on the single read port of the
//   element RAM and one pair of compares.
//   heap: the n heap words, index 0 upward, last_out on the final one. Each
//   word is read from the RAM, then loaded into the output register when
//   that is free; a stall holds the output register and the sequencer.
//   Loading of the next array starts while the final word still waits.
//   Reset: arst_n clears the count, sequencer and output valid; stored
//   elements are not cleared and are only read after being written.
`include "max_heap_builder_unit_defines.svh"

module max_heap_builder_unit #(
	parameter int DEPTH = mhb_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mhb_in_if.sink      elem,
	mhb_out_if.source   heap
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = AW + 2;
	localparam int DW = mhb_pkg::DATA_W;

	mhb_pkg::state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        k_q;
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        e_q;
	logic signed [DW-1:0] pv_q;
	logic signed [DW-1:0] lval_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] out_value_q;
	logic                 out_last_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [DW-1:0]        ram_rdata;

	logic                 in_fire;
	logic                 has_room;
	logic [CW-1:0]        n_next;
	logic [CW-1:0]        k_dec;
	logic [XW-1:0]        lc;
	logic [XW-1:0]        rc;
	logic [XW-1:0]        n_x;
	logic                 lc_ok;
	logic                 rc_ok;
	logic signed [DW-1:0] rval;
	logic                 l_gt;
	logic                 r_gt;
	logic signed [DW-1:0] sel_v;
	logic [XW-1:0]        sel_p;
	logic signed [DW-1:0] big_v;
	logic [XW-1:0]        big_p;
	logic                 moved;
	logic                 out_free;
	logic                 load_out;
	logic                 e_last;

	mhb_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_fire  = elem.valid && elem.ready;
	assign has_room = count_q < CW'(DEPTH);
	assign n_next   = has_room ? count_q + 1'b1 : count_q;
	assign k_dec    = k_q - 1'b1;

	assign lc    = XW'({pos_q, 1'b1});
	assign rc    = lc + 1'b1;
	assign n_x   = XW'(n_q);
	assign lc_ok = lc < n_x;
	assign rc_ok = rc < n_x;

	assign rval  = $signed(ram_rdata);
	assign l_gt  = lval_q > pv_q;
	assign sel_v = l_gt ? lval_q : pv_q;
	assign sel_p = l_gt ? lc : XW'(pos_q);
	assign r_gt  = rc_ok && (rval > sel_v);
	assign big_v = r_gt ? rval : sel_v;
	assign big_p = r_gt ? rc : sel_p;
	assign moved = l_gt || r_gt;

	assign out_free = !out_valid_q || heap.ready;
	assign load_out = (state_q == mhb_pkg::ST_EWAIT) && out_free;
	assign e_last   = CW'(e_q) == (n_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mhb_pkg::ST_LOAD: begin
				if (in_fire && elem.last_item) begin
					state_d = mhb_pkg::ST_HNEXT;
				end
			end
			mhb_pkg::ST_HNEXT: begin
				state_d = (k_q == '0) ? mhb_pkg::ST_ERD : mhb_pkg::ST_HCAP;
			end
			mhb_pkg::ST_HCAP: begin
				state_d = mhb_pkg::ST_CHILD;
			end
			mhb_pkg::ST_CHILD: begin
				state_d = lc_ok ? mhb_pkg::ST_RDR : mhb_pkg::ST_HNEXT;
			end
			mhb_pkg::ST_RDR: begin
				state_d = mhb_pkg::ST_CMP;
			end
			mhb_pkg::ST_CMP: begin
				state_d = moved ? mhb_pkg::ST_CHILD : mhb_pkg::ST_HNEXT;
			end
			mhb_pkg::ST_ERD: begin
				state_d = mhb_pkg::ST_EWAIT;
			end
			mhb_pkg::ST_EWAIT: begin
				if (out_free) begin
					state_d = e_last ? mhb_pkg::ST_LOAD : mhb_pkg::ST_ERD;
				end
			end
			default: begin
				state_d = mhb_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		elem.ready = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = pv_q;
		ram_re     = 1'b0;
		ram_raddr  = pos_q;
		unique case (state_q)
			mhb_pkg::ST_LOAD: begin
				elem.ready = 1'b1;
				ram_we     = in_fire && has_room;
				ram_waddr  = count_q[AW-1:0];
				ram_wdata  = elem.elem_value;
			end
			mhb_pkg::ST_HNEXT: begin
				ram_re    = k_q != '0;
				ram_raddr = k_dec[AW-1:0];
			end
			mhb_pkg::ST_HCAP: begin
			end
			mhb_pkg::ST_CHILD: begin
				ram_we    = !lc_ok;
				ram_re    = lc_ok;
				ram_raddr = lc[AW-1:0];
			end
			mhb_pkg::ST_RDR: begin
				ram_re    = 1'b1;
				ram_raddr = rc[AW-1:0];
			end
			mhb_pkg::ST_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = moved ? big_v : pv_q;
			end
			mhb_pkg::ST_ERD: begin
				ram_re    = 1'b1;
				ram_raddr = e_q;
			end
			mhb_pkg::ST_EWAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhb_pkg::ST_LOAD;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mhb_pkg::ST_LOAD: begin
					if (in_fire) begin
						if (elem.last_item) begin
							count_q <= '0;
							n_q     <= n_next;
							k_q     <= n_next >> 1;
							e_q     <= '0;
						end else begin
							count_q <= n_next;
						end
					end
				end
				mhb_pkg::ST_HNEXT: begin
					if (k_q != '0) begin
						k_q   <= k_dec;
						pos_q <= k_dec[AW-1:0];
					end
				end
				mhb_pkg::ST_CMP: begin
					if (moved) begin
						pos_q <= big_p[AW-1:0];
					end
				end
				mhb_pkg::ST_EWAIT: begin
					if (out_free) begin
						e_q <= e_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mhb_pkg::ST_HCAP) begin
			pv_q <= $signed(ram_rdata);
		end
		if (state_q == mhb_pkg::ST_RDR) begin
			lval_q <= $signed(ram_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (heap.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= $signed(ram_rdata);
			out_last_q  <= e_last;
		end
	end

	assign heap.valid      = out_valid_q;
	assign heap.heap_value = out_value_q;
	assign heap.last_out   = out_last_q;

	`MHB_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`MHB_ASSERT(a_k_bound, clk, arst_n, k_q <= (n_q >> 1))
	`MHB_ASSERT(a_cmp_has_left, clk, arst_n, (state_q == mhb_pkg::ST_CMP) |-> lc_ok)
	`MHB_ASSERT(a_sift_in_range, clk, arst_n,
		(state_q == mhb_pkg::ST_CHILD) |-> (CW'(pos_q) < n_q))
	`MHB_ASSERT_NEVER(a_count_idle, clk, arst_n,
		(state_q != mhb_pkg::ST_LOAD) && (count_q != '0))

endmodule
